@@ rtl/tcw_pkg.sv @@
// shared types and constants for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // request action codes
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // configuration register indexes
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    // character and cell constants
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [15:0] RESET_CELL   = 16'h0F20;
    localparam logic [3:0]  RESET_FG     = 4'hF;
    localparam logic [3:0]  RESET_BG     = 4'h0;

    // one request
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  char_code;
        logic [10:0] read_address;
    } req_t;

    // one result
    typedef struct packed {
        logic [10:0] cursor_position;
        logic [15:0] read_cell;
        logic        scrolled;
    } rsp_t;

    // datapath operation for the current cycle
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_PUT,
        OP_SCROLL,
        OP_FILL_INIT,
        OP_FILL_CLEAR,
        OP_READ,
        OP_FINISH
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic overflow;
        logic sweep_last;
    } dp_status_t;

endpackage

@@ rtl/tcw_ctrl.sv @@
// controller state machine for the text console writer
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             action,
    input  tcw_pkg::dp_status_t    status,
    output tcw_pkg::ctrl_cmd_t     cmd,
    output logic                   busy,
    output logic                   done
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCROLL,
        S_CLEAR,
        S_READ,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;
    logic   accept;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (status.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_PUT:   state_next = S_PUT;
                        ACT_CLEAR: state_next = S_CLEAR;
                        ACT_READ:  state_next = S_READ;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_PUT:
            begin
                state_next = status.overflow ? S_SCROLL : S_FINISH;
            end
            S_SCROLL, S_CLEAR:
            begin
                if (status.sweep_last)
                    state_next = S_FINISH;
            end
            S_READ:   state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath command decode
    always_comb
    begin
        cmd.accept = accept;
        unique case (state_reg)
            S_INIT:   cmd.op = OP_FILL_INIT;
            S_PUT:    cmd.op = OP_PUT;
            S_SCROLL: cmd.op = OP_SCROLL;
            S_CLEAR:  cmd.op = OP_FILL_CLEAR;
            S_READ:   cmd.op = OP_READ;
            S_FINISH: cmd.op = OP_FINISH;
            default:  cmd.op = OP_IDLE;
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
        end
    end

    // every accepted request makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not make the block busy");

    // the strobe follows the finishing cycle only
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_FINISH))
        else $error("result strobe without a finishing cycle");

    // a put that stays on screen finishes at once
    a_put_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) && !status.overflow |=> state_reg == S_FINISH)
        else $error("put without overflow did not finish");

endmodule

@@ rtl/tcw_datapath.sv @@
// screen store, cursor, colour registers and sweep counter
`timescale 1ns / 1ps

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcw_pkg::ctrl_cmd_t     cmd,
    output tcw_pkg::dp_status_t    status,
    input  tcw_pkg::req_t          request,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [3:0]             cfg_data,
    output tcw_pkg::rsp_t          result
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int SW    = CNTW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int PW    = (AW > 11) ? AW : 11;
    localparam int CMPW  = PW + 1;

    // screen store
    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;

    logic [RW-1:0]   row_reg, row_next;
    logic [CLW-1:0]  col_reg, col_next;
    logic [3:0]      fg_reg, fg_next;
    logic [3:0]      bg_reg, bg_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            scrolled_reg, scrolled_next;
    req_t            req_reg;
    rsp_t            result_reg;

    logic [AW-1:0]   lin_addr;
    logic [PW-1:0]   pos_wide;
    logic [CMPW-1:0] ra_ext;
    logic            in_range;
    logic            is_newline;
    logic            adv_row;
    logic            last_row;
    logic [CNTW-1:0] cnt_m1;
    logic [SW-1:0]   scroll_src;
    logic            copy_region;
    logic            sweep_last;
    logic [15:0]     blank;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [15:0]     wdata;
    logic            re;
    logic [AW-1:0]   raddr;

    // address arithmetic
    assign lin_addr    = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign pos_wide    = PW'(lin_addr);
    assign ra_ext      = CMPW'(req_reg.read_address);
    assign in_range    = ra_ext < CMPW'(CELLS);
    assign is_newline  = (req_reg.char_code == NEWLINE_CODE);
    assign last_row    = (row_reg == RW'(ROWS - 1));
    assign adv_row     = is_newline || (col_reg == CLW'(COLUMNS - 1));
    assign cnt_m1      = cnt_reg - CNTW'(1);
    assign scroll_src  = SW'(cnt_reg) + SW'(COLUMNS);
    assign copy_region = cnt_m1 < CNTW'(CELLS - COLUMNS);
    assign sweep_last  = (cnt_reg == CNTW'(CELLS));
    assign blank       = {bg_reg, fg_reg, SPACE_CODE};

    assign status.overflow   = adv_row && last_row;
    assign status.sweep_last = sweep_last;
    assign result            = result_reg;

    // store port select
    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_m1[AW-1:0];
        wdata = blank;
        re    = 1'b0;
        raddr = scroll_src[AW-1:0];
        unique case (cmd.op)
            OP_PUT:
            begin
                we    = !is_newline;
                waddr = lin_addr;
                wdata = {bg_reg, fg_reg, req_reg.char_code};
            end
            OP_SCROLL:
            begin
                we    = (cnt_reg != '0);
                wdata = copy_region ? rdata_reg : blank;
                re    = scroll_src < SW'(CELLS);
            end
            OP_FILL_INIT:
            begin
                we    = (cnt_reg != '0);
                wdata = RESET_CELL;
            end
            OP_FILL_CLEAR:
            begin
                we    = (cnt_reg != '0);
            end
            OP_READ:
            begin
                re    = in_range;
                raddr = ra_ext[AW-1:0];
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // cursor, colours, sweep counter
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        cnt_next      = cnt_reg;
        scrolled_next = scrolled_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FG:  fg_next = cfg_data;
                REG_BG:  bg_next = cfg_data;
                default: fg_next = fg_reg;
            endcase
        end

        if (cmd.accept)
            scrolled_next = 1'b0;

        case (cmd.op)
            OP_PUT:
            begin
                if (adv_row)
                begin
                    col_next = '0;
                    if (!last_row)
                        row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CLW'(1);
                end
            end
            OP_SCROLL, OP_FILL_INIT, OP_FILL_CLEAR:
            begin
                cnt_next = sweep_last ? '0 : cnt_reg + CNTW'(1);
                if (cmd.op == OP_SCROLL)
                    scrolled_next = 1'b1;
                if (cmd.op == OP_FILL_CLEAR)
                begin
                    row_next = '0;
                    col_next = '0;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            fg_reg       <= RESET_FG;
            bg_reg       <= RESET_BG;
            cnt_reg      <= '0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            cnt_reg      <= cnt_next;
            scrolled_reg <= scrolled_next;
        end
    end

    // request and result capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            req_reg <= request;
        if (cmd.op == OP_FINISH)
        begin
            result_reg.cursor_position <= pos_wide[10:0];
            result_reg.read_cell       <= (req_reg.action == ACT_READ && in_range)
                                          ? rdata_reg : 16'h0000;
            result_reg.scrolled        <= scrolled_reg;
        end
    end

    // store write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // store read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    // cursor column always on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < CLW'(COLUMNS - 1)) || (col_reg == CLW'(COLUMNS - 1)))
        else $error("cursor column off screen");

    // a scroll runs with the cursor parked at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SCROLL) |-> (last_row && col_reg == '0))
        else $error("scroll with cursor away from the bottom row start");

    // the sweep counter rests at zero between sweeps
    a_sweep_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.op == OP_SCROLL || cmd.op == OP_FILL_INIT || cmd.op == OP_FILL_CLEAR)
        |-> cnt_reg == '0)
        else $error("sweep counter not at rest outside a sweep");

endmodule

@@ rtl/text_console_writer.sv @@
// text console writer top level: controller plus screen datapath
//
// usage
//   requests: drive request and raise start; a request is taken at an edge
//   where start is high and busy is low. action put writes char_code at the
//   cursor (newline only moves it), clear blanks the screen in the current
//   colour, read returns one cell of the screen store.
//   results: done is high for one cycle with the result; the receiver
//   cannot stall, so every result must be taken in that cycle.
//   configuration: cfg_valid with cfg_index and cfg_data writes the
//   foreground or background colour; cfg_ready is always high.
// sequence (CELLS = ROWS * COLUMNS)
//   put without scroll and read pass through their own state and then the
//   finishing state; an unused action goes straight to the finishing state;
//   a put that scrolls and a clear sweep all CELLS cells before finishing;
//   copy and fill run one cell a cycle through the one write port
// reset
//   after rst_n releases, a clearing pass writes every cell with white on
//   black spaces with busy high; colour writes are taken
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  tcw_pkg::req_t  request,
    output logic           done,
    output tcw_pkg::rsp_t  result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [3:0]     cfg_data
);
    import tcw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // sequencing
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (request.action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // screen store and cursor
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule
